FILE: hdl/ypc_pkg.sv
package ypc_pkg;

  // operand width of the shared serial multiplier
  localparam int MUL_W = 32;

  // operation codes
  localparam logic [2:0] OP_FWD   = 3'd0;
  localparam logic [2:0] OP_BACK  = 3'd1;
  localparam logic [2:0] OP_LEFT  = 3'd2;
  localparam logic [2:0] OP_RIGHT = 3'd3;
  localparam logic [2:0] OP_TURN  = 3'd4;

  // register indexes
  localparam logic [2:0] REG_MOVE_STEP = 3'd0;
  localparam logic [2:0] REG_TURN_GAIN = 3'd1;
  localparam logic [2:0] REG_SCREEN_W  = 3'd2;
  localparam logic [2:0] REG_SCREEN_H  = 3'd3;
  localparam logic [2:0] REG_UP_X      = 3'd4;
  localparam logic [2:0] REG_UP_Y      = 3'd5;
  localparam logic [2:0] REG_UP_Z      = 3'd6;

  // angles in degrees * 65536
  localparam logic signed [25:0] ANG_90  = 26'sd5898240;
  localparam logic signed [25:0] ANG_180 = 26'sd11796480;
  localparam logic signed [25:0] ANG_360 = 26'sd23592960;

  localparam int CORDIC_STEPS = 16;
  localparam logic signed [31:0] CORDIC_K = 32'sd652032874;
  localparam logic [21:0] ATAN_TAB [CORDIC_STEPS] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
    22'd234379,  22'd117304,  22'd58666,  22'd29335,
    22'd14668,   22'd7334,    22'd3667,   22'd1833,
    22'd917,     22'd458,     22'd229,    22'd115
  };

  // angles in degrees * 128
  localparam logic signed [21:0] DEG_FULL   = 22'sd46080;
  localparam logic signed [21:0] TILT_LIMIT = 22'sd11392;

  // Q16.8 location range
  localparam logic signed [25:0] LOC_MAX = 26'sd8388607;
  localparam logic signed [25:0] LOC_MIN = -26'sd8388608;

endpackage

FILE: hdl/ypc_mul.sv
// Shift-add multiplier, one multiplier bit per cycle, sign-magnitude.
module ypc_mul import ypc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic signed [MUL_W-1:0]   a,
  input  logic signed [MUL_W-1:0]   b,
  output logic                      done,
  output logic signed [2*MUL_W-1:0] p
);

  localparam int CW = $clog2(MUL_W);

  logic [MUL_W-1:0] a_mag;
  logic [MUL_W-1:0] hi;
  logic [MUL_W-1:0] lo;
  logic [MUL_W:0]   sum;
  logic [CW-1:0]    cnt;
  logic             neg;
  logic             busy;
  logic             fin;

  assign sum = {1'b0, hi} + (lo[0] ? {1'b0, a_mag} : {(MUL_W+1){1'b0}});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= fin;
      fin  <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(MUL_W - 1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_mag <= a[MUL_W-1] ? -a : a;
      lo    <= b[MUL_W-1] ? -b : b;
      hi    <= '0;
      neg   <= a[MUL_W-1] ^ b[MUL_W-1];
    end else if (busy) begin
      hi <= sum[MUL_W:1];
      lo <= {sum[0], lo[MUL_W-1:1]};
    end
    if (fin) begin
      p <= neg ? -$signed({hi, lo}) : $signed({hi, lo});
    end
  end

endmodule

FILE: hdl/ypc_cordic.sv
// Rotation-mode CORDIC, one micro-rotation per cycle.
module ypc_cordic import ypc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [16:0] ang,
  output logic               done,
  output logic signed [31:0] s,
  output logic signed [31:0] c
);

  logic signed [25:0] a_in;
  logic signed [25:0] a_wrap;
  logic signed [25:0] a;
  logic signed [31:0] x;
  logic signed [31:0] y;
  logic signed [31:0] dx;
  logic signed [31:0] dy;
  logic [3:0]         cnt;
  logic               neg;
  logic               fold;
  logic               busy;
  logic               fin;

  assign a_in = {ang, 9'b0};

  always_comb begin
    if (a_in > ANG_180) begin
      a_wrap = a_in - ANG_360;
    end else if (a_in <= -ANG_180) begin
      a_wrap = a_in + ANG_360;
    end else begin
      a_wrap = a_in;
    end
  end

  assign dx = y >>> cnt;
  assign dy = x >>> cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      fold <= 1'b0;
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= fin;
      fin  <= 1'b0;
      fold <= start;
      if (fold) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == 4'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a <= a_wrap;
    end else if (fold) begin
      // bring the angle into the right half plane
      x <= CORDIC_K;
      y <= '0;
      if (a > ANG_90) begin
        a   <= ANG_180 - a;
        neg <= 1'b1;
      end else if (a < -ANG_90) begin
        a   <= -ANG_180 - a;
        neg <= 1'b1;
      end else begin
        neg <= 1'b0;
      end
    end else if (busy) begin
      if (a >= 0) begin
        x <= x - dx;
        y <= y + dy;
        a <= a - $signed({4'b0, ATAN_TAB[cnt]});
      end else begin
        x <= x + dx;
        y <= y - dy;
        a <= a + $signed({4'b0, ATAN_TAB[cnt]});
      end
    end
    if (fin) begin
      s <= y;
      c <= neg ? -x : x;
    end
  end

endmodule

FILE: hdl/ypc_sqrt.sv
// Digit-by-digit integer square root, two radicand bits per cycle.
module ypc_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] n,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] nsh;
  logic [33:0] rem;
  logic [31:0] r;
  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic [35:0] diff;
  logic [4:0]  cnt;
  logic        busy;
  logic        fin;

  assign rem_sh = {rem, nsh[63:62]};
  assign trial  = {2'b0, r, 2'b01};
  assign diff   = rem_sh - trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= fin;
      fin  <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nsh <= n;
      rem <= '0;
      r   <= '0;
    end else if (busy) begin
      nsh <= {nsh[61:0], 2'b00};
      if (rem_sh >= trial) begin
        rem <= diff[33:0];
        r   <= {r[30:0], 1'b1};
      end else begin
        rem <= rem_sh[33:0];
        r   <= {r[30:0], 1'b0};
      end
    end
    if (fin) begin
      root <= r;
    end
  end

endmodule

FILE: hdl/ypc_div.sv
// Restoring divider for normalization: round(num * 16384 / den), ties away
// from zero; one quotient bit per cycle. Zero divisor gives zero.
module ypc_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] num,
  input  logic [31:0]        den,
  output logic               done,
  output logic signed [15:0] q
);

  logic [31:0] mag;
  logic [46:0] rem;
  logic [46:0] dsh;
  logic [14:0] qb;
  logic [3:0]  cnt;
  logic        neg;
  logic        zero;
  logic        busy;
  logic        fin;

  assign mag = num[31] ? -num : num;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= fin;
      fin  <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == 4'd14) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= {1'b0, mag, 14'b0} + {16'b0, den[31:1]};
      dsh  <= {1'b0, den, 14'b0};
      qb   <= '0;
      neg  <= num[31];
      zero <= (den == 32'd0);
    end else if (busy) begin
      dsh <= {1'b0, dsh[46:1]};
      if (rem >= dsh) begin
        rem <= rem - dsh;
        qb  <= {qb[13:0], 1'b1};
      end else begin
        qb  <= {qb[13:0], 1'b0};
      end
    end
    if (fin) begin
      if (zero) begin
        q <= '0;
      end else begin
        q <= neg ? -$signed({1'b0, qb}) : $signed({1'b0, qb});
      end
    end
  end

endmodule

FILE: hdl/yaw_pitch_camera_update_core.sv
// First-person camera update. The block holds heading and tilt (degrees*128),
// a Q16.8 location and three Q2.14 unit vectors (view, side, top). Codes 0..3
// step the location forward, back, left or right along the view or side
// vector by move_step, saturating; code 4 turns by the cursor offset from the
// screen center times turn_gain, clamps tilt to +-89 degrees, wraps heading
// and rebuilds all three vectors; other codes change nothing. Every item
// gives one result with the location and the vectors. One item is worked at
// a time. Nearly all of the time of a move or a turn goes to the shared
// bit-serial multiplier (3 products per move, 25 per turn); the rest of a
// turn is the heading wrap, two CORDIC runs, three square roots and nine
// divisions. A finished result sits in the output register, so the next
// item is taken while it waits. Config writes are always ready and take
// effect at once; world up is read only when a turn builds the side vector.
module yaw_pitch_camera_update_core import ypc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // config write
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  // item input
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         operation,
  input  logic [11:0]        mouse_x,
  input  logic [11:0]        mouse_y,
  // result output
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] loc_x,
  output logic signed [23:0] loc_y,
  output logic signed [23:0] loc_z,
  output logic signed [15:0] view_x,
  output logic signed [15:0] view_y,
  output logic signed [15:0] view_z,
  output logic signed [15:0] side_x,
  output logic signed [15:0] side_y,
  output logic signed [15:0] side_z,
  output logic signed [15:0] top_x,
  output logic signed [15:0] top_y,
  output logic signed [15:0] top_z
);

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_MULW  = 4'd2;
  localparam logic [3:0] S_WRAP  = 4'd3;
  localparam logic [3:0] S_COR   = 4'd4;
  localparam logic [3:0] S_CORW  = 4'd5;
  localparam logic [3:0] S_SQRT  = 4'd6;
  localparam logic [3:0] S_SQRTW = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_DIVW  = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  // what the product in flight is for
  localparam logic [2:0] J_DX   = 3'd0;
  localparam logic [2:0] J_DY   = 3'd1;
  localparam logic [2:0] J_RAW0 = 3'd2;
  localparam logic [2:0] J_RAW2 = 3'd3;
  localparam logic [2:0] J_SQ   = 3'd4;
  localparam logic [2:0] J_CRS  = 3'd5;
  localparam logic [2:0] J_MOV  = 3'd6;

  // which vector the normalizer is producing
  localparam logic [1:0] P_VIEW = 2'd0;
  localparam logic [1:0] P_SIDE = 2'd1;
  localparam logic [1:0] P_TOP  = 2'd2;

  // config registers
  logic [15:0]        move_step;
  logic [15:0]        turn_gain;
  logic [12:0]        screen_w;
  logic [12:0]        screen_h;
  logic signed [15:0] upv [3];

  // camera state
  logic [15:0]        hd;
  logic signed [14:0] tl;
  logic signed [23:0] loc [3];
  logic signed [15:0] vw [3];
  logic signed [15:0] sd [3];
  logic signed [15:0] tp [3];

  // sequencer
  logic [3:0]         state;
  logic [2:0]         job;
  logic [2:0]         cnt;
  logic [1:0]         phase;
  logic               cor_sel;
  logic [2:0]         op;
  logic [11:0]        mx;
  logic [11:0]        my;

  // work registers
  logic signed [21:0] hnew;
  logic signed [31:0] sh;
  logic signed [31:0] ch;
  logic signed [31:0] sp;
  logic signed [31:0] cp;
  logic signed [31:0] va [3];
  logic signed [31:0] t0;
  logic [63:0]        sumsq;
  logic [31:0]        len;

  // unit hookups
  logic                      mul_done;
  logic signed [MUL_W-1:0]   mul_a;
  logic signed [MUL_W-1:0]   mul_b;
  logic signed [2*MUL_W-1:0] mul_p;
  logic                      cor_done;
  logic signed [16:0]        cor_ang;
  logic signed [31:0]        cor_s;
  logic signed [31:0]        cor_c;
  logic                      sqrt_done;
  logic [31:0]               sqrt_root;
  logic                      div_done;
  logic signed [15:0]        div_q;

  // derived values
  logic signed [14:0] dx2;
  logic signed [14:0] dy2;
  logic [1:0]         k;
  logic [1:0]         k1;
  logic [1:0]         k2;
  logic [1:0]         ia;
  logic [1:0]         ib;
  logic               sub;
  logic signed [63:0] p_r10;
  logic signed [63:0] p_r14;
  logic signed [63:0] p_s30;
  logic signed [21:0] tsum;
  logic signed [25:0] lsum;
  logic signed [25:0] lsat;
  logic               out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign out_free  = !out_valid || !out_stall;

  // cursor offsets in half pixels
  assign dx2 = $signed({2'b0, mx, 1'b0}) - $signed({2'b0, screen_w});
  assign dy2 = $signed({2'b0, screen_h}) - $signed({2'b0, my, 1'b0});

  // cross product indexes: term 0 is a[k1]*b[k2], term 1 is a[k2]*b[k1]
  assign k  = cnt[2:1];
  assign k1 = (k == 2'd2) ? 2'd0 : k + 2'd1;
  assign k2 = (k == 2'd0) ? 2'd2 : k - 2'd1;
  assign ia = cnt[0] ? k2 : k1;
  assign ib = cnt[0] ? k1 : k2;

  // backward and left subtract
  assign sub = (op == OP_BACK) || (op == OP_LEFT);

  assign p_r10 = (mul_p + 64'sd512) >>> 10;
  assign p_r14 = (mul_p + 64'sd8192) >>> 14;
  assign p_s30 = mul_p >>> 30;
  assign tsum  = 22'(tl) + p_r10[21:0];
  assign lsum  = sub ? 26'(loc[cnt[1:0]]) - p_r14[25:0]
                     : 26'(loc[cnt[1:0]]) + p_r14[25:0];
  assign lsat  = (lsum > LOC_MAX) ? LOC_MAX : (lsum < LOC_MIN) ? LOC_MIN : lsum;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (job)
      J_DX: begin
        mul_a = 32'(dx2);
        mul_b = $signed({16'b0, turn_gain});
      end
      J_DY: begin
        mul_a = 32'(dy2);
        mul_b = $signed({16'b0, turn_gain});
      end
      J_RAW0: begin
        mul_a = ch;
        mul_b = cp;
      end
      J_RAW2: begin
        mul_a = sh;
        mul_b = cp;
      end
      J_SQ: begin
        mul_a = va[cnt[1:0]];
        mul_b = va[cnt[1:0]];
      end
      J_CRS: begin
        // side = view x up, top = side x view
        if (phase == P_SIDE) begin
          mul_a = 32'(vw[ia]);
          mul_b = 32'(upv[ib]);
        end else begin
          mul_a = 32'(sd[ia]);
          mul_b = 32'(vw[ib]);
        end
      end
      J_MOV: begin
        mul_a = (op == OP_LEFT || op == OP_RIGHT) ? 32'(sd[cnt[1:0]])
                                                  : 32'(vw[cnt[1:0]]);
        mul_b = $signed({16'b0, move_step});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign cor_ang = cor_sel ? 17'(tl) : $signed({1'b0, hd});

  ypc_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_MUL),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  ypc_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_COR),
    .ang   (cor_ang),
    .done  (cor_done),
    .s     (cor_s),
    .c     (cor_c)
  );

  ypc_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_SQRT),
    .n     (sumsq),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  ypc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_DIV),
    .num   (va[cnt[1:0]]),
    .den   (len),
    .done  (div_done),
    .q     (div_q)
  );

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      move_step <= 16'd256;
      turn_gain <= 16'd6554;
      screen_w  <= 13'd800;
      screen_h  <= 13'd600;
      upv[0]    <= 16'sd0;
      upv[1]    <= 16'sd16384;
      upv[2]    <= 16'sd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MOVE_STEP: move_step <= cfg_data;
        REG_TURN_GAIN: turn_gain <= cfg_data;
        REG_SCREEN_W:  screen_w  <= cfg_data[12:0];
        REG_SCREEN_H:  screen_h  <= cfg_data[12:0];
        REG_UP_X:      upv[0]    <= cfg_data;
        REG_UP_Y:      upv[1]    <= cfg_data;
        REG_UP_Z:      upv[2]    <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer and camera state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      job     <= J_DX;
      cnt     <= '0;
      phase   <= P_VIEW;
      cor_sel <= 1'b0;
      hd      <= 16'd34560;
      tl      <= '0;
      loc[0]  <= '0;
      loc[1]  <= '0;
      loc[2]  <= '0;
      vw[0]   <= 16'sd0;
      vw[1]   <= 16'sd0;
      vw[2]   <= -16'sd16384;
      sd[0]   <= 16'sd16384;
      sd[1]   <= 16'sd0;
      sd[2]   <= 16'sd0;
      tp[0]   <= 16'sd0;
      tp[1]   <= 16'sd16384;
      tp[2]   <= 16'sd0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op    <= operation;
            mx    <= mouse_x;
            my    <= mouse_y;
            cnt   <= '0;
            phase <= P_VIEW;
            case (operation) inside
              OP_FWD, OP_BACK, OP_LEFT, OP_RIGHT: begin
                job   <= J_MOV;
                state <= S_MUL;
              end
              OP_TURN: begin
                job   <= J_DX;
                state <= S_MUL;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_MUL: state <= S_MULW;
        S_MULW: begin
          if (mul_done) begin
            state <= S_MUL;
            case (job)
              J_DX: begin
                hnew <= $signed({6'b0, hd}) + p_r10[21:0];
                job  <= J_DY;
              end
              J_DY: begin
                if (tsum > TILT_LIMIT) begin
                  tl <= 15'(TILT_LIMIT);
                end else if (tsum < -TILT_LIMIT) begin
                  tl <= 15'(-TILT_LIMIT);
                end else begin
                  tl <= tsum[14:0];
                end
                state <= S_WRAP;
              end
              J_RAW0: begin
                va[0] <= p_s30[31:0];
                job   <= J_RAW2;
              end
              J_RAW2: begin
                va[2] <= p_s30[31:0];
                va[1] <= sp;
                job   <= J_SQ;
                cnt   <= '0;
                sumsq <= '0;
              end
              J_SQ: begin
                sumsq <= sumsq + mul_p;
                cnt   <= cnt + 3'd1;
                if (cnt == 3'd2) begin
                  state <= S_SQRT;
                end
              end
              J_CRS: begin
                if (!cnt[0]) begin
                  t0 <= mul_p[31:0];
                end else begin
                  va[k] <= t0 - mul_p[31:0];
                end
                cnt <= cnt + 3'd1;
                if (cnt == 3'd5) begin
                  job   <= J_SQ;
                  cnt   <= '0;
                  sumsq <= '0;
                end
              end
              J_MOV: begin
                loc[cnt[1:0]] <= lsat[23:0];
                cnt <= cnt + 3'd1;
                if (cnt == 3'd2) begin
                  state <= S_DONE;
                end
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_WRAP: begin
          // heading mod 360 degrees, one turn per cycle
          if (hnew >= DEG_FULL) begin
            hnew <= hnew - DEG_FULL;
          end else if (hnew < 0) begin
            hnew <= hnew + DEG_FULL;
          end else begin
            hd      <= hnew[15:0];
            cor_sel <= 1'b0;
            state   <= S_COR;
          end
        end
        S_COR: state <= S_CORW;
        S_CORW: begin
          if (cor_done) begin
            if (!cor_sel) begin
              sh      <= cor_s;
              ch      <= cor_c;
              cor_sel <= 1'b1;
              state   <= S_COR;
            end else begin
              sp    <= cor_s;
              cp    <= cor_c;
              job   <= J_RAW0;
              state <= S_MUL;
            end
          end
        end
        S_SQRT: state <= S_SQRTW;
        S_SQRTW: begin
          if (sqrt_done) begin
            len   <= sqrt_root;
            cnt   <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: state <= S_DIVW;
        S_DIVW: begin
          if (div_done) begin
            case (phase)
              P_VIEW:  vw[cnt[1:0]] <= div_q;
              P_SIDE:  sd[cnt[1:0]] <= div_q;
              default: tp[cnt[1:0]] <= div_q;
            endcase
            cnt   <= cnt + 3'd1;
            state <= S_DIV;
            if (cnt == 3'd2) begin
              cnt <= '0;
              job <= J_CRS;
              if (phase == P_VIEW) begin
                phase <= P_SIDE;
                state <= S_MUL;
              end else if (phase == P_SIDE) begin
                phase <= P_TOP;
                state <= S_MUL;
              end else begin
                state <= S_DONE;
              end
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      loc_x  <= loc[0];
      loc_y  <= loc[1];
      loc_z  <= loc[2];
      view_x <= vw[0];
      view_y <= vw[1];
      view_z <= vw[2];
      side_x <= sd[0];
      side_y <= sd[1];
      side_z <= sd[2];
      top_x  <= tp[0];
      top_y  <= tp[1];
      top_z  <= tp[2];
    end
  end

  a_mul_done_wait: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> state == S_MULW)
    else $error("multiplier result with no consumer");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> out_valid)
    else $error("finished item not presented");

  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    $signed({6'b0, hd}) < DEG_FULL)
    else $error("heading out of range");

  a_tilt_range: assert property (@(posedge clk) disable iff (rst)
    22'(tl) <= TILT_LIMIT && 22'(tl) >= -TILT_LIMIT)
    else $error("tilt out of range");

endmodule
